// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/bcdt_pkg.sv =====
package bcdt_pkg;

  localparam logic [6:0] CH_SPACE = 7'd32;
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_W     = 7'd87;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Result slots of one job, emitted from the highest set slot down.
  localparam int SLOT_N      = 9;
  localparam int SLOT_REPORT = 0;
  localparam int SLOT_BEEP   = 1;
  localparam int SLOT_CHAR0  = 2;
  localparam int SLOT_IDX_W  = $clog2(SLOT_N);

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_START    = 3'd1,
    FUNC_STOP     = 3'd2,
    FUNC_SET_WAIT = 3'd3,
    FUNC_DISP_ON  = 3'd4,
    FUNC_DISP_OFF = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_BEEP   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SLOT_N-1:0] slots;
    logic [6:0][6:0]   chars;
    logic [14:0]       total_minutes;
    logic [5:0]        total_seconds;
    logic              display_enabled;
  } job_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    return CH_ZERO + 7'(d);
  endfunction

  function automatic logic [3:0] mod10_u8(input logic [7:0] x);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = 16'(x) * 16'd205;
    q    = prod[15:11];
    r    = x - 8'(q) * 8'd10;
    return r[3:0];
  endfunction

endpackage

// ===== design/bcdt_if.sv =====
interface bcdt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic       display_on_start;
  logic       call_waiting;

  modport source (output valid, func, display_on_start, call_waiting, input ready);
  modport sink (input valid, func, display_on_start, call_waiting, output ready);
endinterface

interface bcdt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  position;
  logic [6:0]  char_code;
  logic [14:0] total_minutes;
  logic [5:0]  total_seconds;
  logic        display_enabled;
  logic        last;

  modport source (output valid, kind, position, char_code, total_minutes, total_seconds,
                  display_enabled, last, input ready);
  modport sink (input valid, kind, position, char_code, total_minutes, total_seconds,
                display_enabled, last, output ready);
endinterface

interface bcdt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/bcd_call_duration_timer.sv =====
// Call-duration stopwatch. Each accepted input beat is decoded and applied to the
// counter state in the cycle it is taken, and any results it causes are queued as
// one job in a four-entry queue. The output side expands a job into one result beat
// per cycle, while the result port is not stalled, through a registered output stage.
// When the output side is idle, a job passes through the queue storage and then the
// output register before its first result is valid. The input side takes one beat per
// cycle while the queue has room. Once four jobs wait behind a stalled result port,
// every input beat is held off, including ticks and commands that cause no result.
module bcd_call_duration_timer
  import bcdt_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  bcdt_in_if.sink    in_ch,
  bcdt_cfg_if.sink   cfg_ch,
  bcdt_out_if.source out_ch
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t wr_job;
  job_t head;

  bcdt_front #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .push  (push),
    .job   (wr_job),
    .full  (full)
  );

  bcdt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(wr_job),
    .full   (full),
    .pop    (pop),
    .rd_data(head),
    .empty  (empty)
  );

  bcdt_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

// ===== design/bcdt_front.sv =====
`include "assert_macros.svh"

module bcdt_front
  import bcdt_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  bcdt_in_if.sink        in_ch,
  bcdt_cfg_if.sink       cfg_ch,
  output logic           push,
  output job_t           job,
  input  logic           full
);

  localparam logic [3:0] PRESCALE_LIMIT = 4'(TICKS_PER_SECOND);

  logic       beep_en_r;
  logic       running_r,  running_nxt;
  logic       disp_r,     disp_nxt;
  logic       marker_r,   marker_nxt;
  logic [3:0] prescale_r, prescale_nxt;
  logic [3:0] so_r,       so_nxt;
  logic [2:0] st_r,       st_nxt;
  logic [3:0] mo_r,       mo_nxt;
  logic [3:0] mt_r,       mt_nxt;
  logic [7:0] hund_r,     hund_nxt;
  logic       redraw;
  func_t      func;

  assign in_ch.ready  = !full;
  assign cfg_ch.ready = 1'b1;
  assign func         = func_t'(in_ch.func);

  always_comb begin
    running_nxt  = running_r;
    disp_nxt     = disp_r;
    marker_nxt   = marker_r;
    prescale_nxt = prescale_r;
    so_nxt       = so_r;
    st_nxt       = st_r;
    mo_nxt       = mo_r;
    mt_nxt       = mt_r;
    hund_nxt     = hund_r;
    redraw       = 1'b0;
    job          = '0;

    if (in_ch.valid && in_ch.ready) begin
      unique case (func)
        FUNC_TICK: begin
          if (running_r) begin
            prescale_nxt = prescale_r + 4'd1;
            if (prescale_nxt >= PRESCALE_LIMIT) begin
              prescale_nxt = '0;
              so_nxt = so_r + 4'd1;
              job.slots[SLOT_CHAR0] = disp_r;
              if (so_nxt >= 4'd10) begin
                so_nxt = '0;
                st_nxt = st_r + 3'd1;
                job.slots[SLOT_CHAR0 + 1] = disp_r;
                if (st_nxt >= 3'd6) begin
                  st_nxt = '0;
                  mo_nxt = mo_r + 4'd1;
                  job.slots[SLOT_CHAR0 + 3] = disp_r;
                  if (mo_nxt >= 4'd10) begin
                    mo_nxt = '0;
                    mt_nxt = mt_r + 4'd1;
                    job.slots[SLOT_CHAR0 + 4] = disp_r;
                    if (mt_nxt >= 4'd10) begin
                      mt_nxt   = '0;
                      hund_nxt = hund_r + 8'd1;
                      job.slots[SLOT_CHAR0 + 5] = disp_r;
                    end
                  end
                end
                job.slots[SLOT_BEEP] = (st_nxt == 3'd5) && beep_en_r;
              end
            end
          end
        end
        FUNC_START: begin
          if (!running_r) begin
            so_nxt       = '0;
            st_nxt       = '0;
            mo_nxt       = '0;
            mt_nxt       = '0;
            hund_nxt     = '0;
            prescale_nxt = '0;
            running_nxt  = 1'b1;
            disp_nxt     = in_ch.display_on_start;
            redraw       = in_ch.display_on_start;
          end
        end
        FUNC_STOP: begin
          if (running_r) begin
            running_nxt = 1'b0;
            job.slots[SLOT_REPORT] = 1'b1;
            job.total_minutes = 15'(hund_r) * 15'd100 + 15'(mt_r) * 15'd10 + 15'(mo_r);
            job.total_seconds = 6'(st_r) * 6'd10 + 6'(so_r);
          end
        end
        FUNC_SET_WAIT: begin
          if (in_ch.call_waiting != marker_r) begin
            marker_nxt = in_ch.call_waiting;
            job.slots[SLOT_CHAR0 + 6] = disp_r;
          end
        end
        FUNC_DISP_ON: begin
          if (!disp_r) begin
            redraw   = 1'b1;
            disp_nxt = 1'b1;
          end
        end
        FUNC_DISP_OFF: begin
          disp_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (redraw) begin
      job.slots[SLOT_CHAR0 +: 7] = '1;
    end
    job.chars[6] = marker_nxt ? CH_W : CH_SPACE;
    job.chars[5] = (redraw && hund_nxt == 8'd0) ? CH_SPACE : digit_char(mod10_u8(hund_nxt));
    job.chars[4] = digit_char(mt_nxt);
    job.chars[3] = digit_char(mo_nxt);
    job.chars[2] = CH_SPACE;
    job.chars[1] = digit_char({1'b0, st_nxt});
    job.chars[0] = digit_char(so_nxt);
    job.display_enabled = disp_nxt;
  end

  assign push = |job.slots;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_en_r  <= 1'b0;
      running_r  <= 1'b0;
      disp_r     <= 1'b0;
      marker_r   <= 1'b0;
      prescale_r <= '0;
      so_r       <= '0;
      st_r       <= '0;
      mo_r       <= '0;
      mt_r       <= '0;
      hund_r     <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        beep_en_r <= cfg_ch.data;
      end
      running_r  <= running_nxt;
      disp_r     <= disp_nxt;
      marker_r   <= marker_nxt;
      prescale_r <= prescale_nxt;
      so_r       <= so_nxt;
      st_r       <= st_nxt;
      mo_r       <= mo_nxt;
      mt_r       <= mt_nxt;
      hund_r     <= hund_nxt;
    end
  end

  `ASSERT_CLK(a_digits_legal, so_r < 4'd10 && st_r < 3'd6 && mo_r < 4'd10 && mt_r < 4'd10, "BCD digit out of range")
  `ASSERT_CLK(a_stopped_no_count, !running_r |=> $stable(so_r) || running_r || $past(func == FUNC_START), "count moved while stopped")

endmodule

// ===== design/bcdt_queue.sv =====
`include "assert_macros.svh"

module bcdt_queue
  import bcdt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_data,
  output logic full,
  input  logic pop,
  output job_t rd_data,
  output logic empty
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full    = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")

endmodule

// ===== design/bcdt_back.sv =====
`include "assert_macros.svh"

module bcdt_back
  import bcdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  bcdt_out_if.source out_ch
);

  logic                  busy_r,  busy_nxt;
  job_t                  job_r,   job_nxt;
  logic [SLOT_N-1:0]     rem_r,   rem_nxt;
  logic                  valid_r, valid_nxt;
  kind_t                 kind_r,  kind_nxt;
  logic [2:0]            pos_r,   pos_nxt;
  logic [6:0]            char_r,  char_nxt;
  logic [14:0]           min_r,   min_nxt;
  logic [5:0]            sec_r,   sec_nxt;
  logic                  disp_r,  disp_nxt;
  logic                  last_r,  last_nxt;

  job_t                  sel;
  logic [SLOT_N-1:0]     rem;
  logic [SLOT_N-1:0]     rem_after;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  advance;
  logic                  have;
  logic                  is_last;

  assign sel       = busy_r ? job_r : head;
  assign rem       = busy_r ? rem_r : head.slots;
  assign advance   = !valid_r || out_ch.ready;
  assign have      = busy_r || !empty;

  always_comb begin
    idx = '0;
    for (int i = 0; i < SLOT_N; i++) begin
      if (rem[i]) begin
        idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign rem_after = rem & ~(SLOT_N'(1) << idx);
  assign is_last   = rem_after == '0;

  always_comb begin
    busy_nxt  = busy_r;
    job_nxt   = job_r;
    rem_nxt   = rem_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    pos_nxt   = pos_r;
    char_nxt  = char_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    disp_nxt  = disp_r;
    last_nxt  = last_r;
    pop       = 1'b0;

    if (advance) begin
      valid_nxt = have;
      if (have) begin
        pos_nxt  = '0;
        char_nxt = '0;
        min_nxt  = '0;
        sec_nxt  = '0;
        disp_nxt = sel.display_enabled;
        last_nxt = is_last;
        if (idx >= SLOT_IDX_W'(SLOT_CHAR0)) begin
          kind_nxt = KIND_CHAR;
          pos_nxt  = 3'(idx - SLOT_IDX_W'(SLOT_CHAR0));
          char_nxt = sel.chars[pos_nxt];
        end else if (idx == SLOT_IDX_W'(SLOT_BEEP)) begin
          kind_nxt = KIND_BEEP;
        end else begin
          kind_nxt = KIND_REPORT;
          min_nxt  = sel.total_minutes;
          sec_nxt  = sel.total_seconds;
        end

        if (busy_r) begin
          busy_nxt = !is_last;
          rem_nxt  = rem_after;
        end else begin
          pop = 1'b1;
          if (!is_last) begin
            busy_nxt = 1'b1;
            job_nxt  = head;
            rem_nxt  = rem_after;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    kind_r <= kind_nxt;
    pos_r  <= pos_nxt;
    char_r <= char_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    disp_r <= disp_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.position        = pos_r;
  assign out_ch.char_code       = char_r;
  assign out_ch.total_minutes   = min_r;
  assign out_ch.total_seconds   = sec_r;
  assign out_ch.display_enabled = disp_r;
  assign out_ch.last            = last_r;

  `ASSERT_CLK(a_busy_has_work, busy_r |-> rem_r != '0, "busy with no slots left")
  `ASSERT_CLK(a_head_has_work, !busy_r && !empty |-> head.slots != '0, "queued job with no results")

endmodule
